// File: rtl/core/cba_pkg.sv
package cba_pkg;

    localparam int NUM_BLOCKS_DEF = 64;

    // scan window of the back end, in blocks per cycle
    localparam int CHUNK   = 8;
    localparam int CHUNK_W = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int LEN_W  = 7;
    localparam int BLK_W  = 6;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int DATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_COUNT = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd2;

    // classified operation handed from front to back
    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_BAD   = 3'd1;
    localparam logic [2:0] OP_SET   = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [LEN_W-1:0] len;
        logic [BLK_W-1:0] blk;
        logic             blk_ok;
    } t_cmd;

endpackage

// File: rtl/core/cba_front.sv
module cba_front #(
    parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [cba_pkg::REQ_W-1:0] i_req_type,
    input  logic [cba_pkg::LEN_W-1:0] i_run_length,
    input  logic [cba_pkg::BLK_W-1:0] i_block_index,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output cba_pkg::t_cmd             o_q_cmd
);

    logic w_len_bad;

    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full;

    assign w_len_bad = (i_run_length == '0) || (32'(i_run_length) > NUM_BLOCKS);

    always_comb begin
        o_q_cmd.len    = i_run_length;
        o_q_cmd.blk    = i_block_index;
        o_q_cmd.blk_ok = 32'(i_block_index) < NUM_BLOCKS;
        case (i_req_type)
            cba_pkg::REQ_ALLOC: begin
                o_q_cmd.op = w_len_bad ? cba_pkg::OP_BAD : cba_pkg::OP_ALLOC;
            end
            cba_pkg::REQ_SET:   o_q_cmd.op = cba_pkg::OP_SET;
            cba_pkg::REQ_CLEAR: o_q_cmd.op = cba_pkg::OP_CLEAR;
            default:            o_q_cmd.op = cba_pkg::OP_QUERY;
        endcase
    end

endmodule

// File: rtl/core/cba_queue.sv
module cba_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cba_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output cba_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    localparam int QD = cba_pkg::QUEUE_DEPTH;
    localparam int QA = cba_pkg::QUEUE_AW;
    localparam int CNT_W = $clog2(QD + 1);

    cba_pkg::t_cmd r_mem [QD];
    logic [QA-1:0]    r_wr_ptr;
    logic [QA-1:0]    r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = r_count == CNT_W'(QD);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QA'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QA'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/core/cba_back.sv
module cba_back #(
    parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  cba_pkg::t_cmd              i_q_cmd,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [cba_pkg::STAT_W-1:0] o_status,
    output logic [cba_pkg::BLK_W-1:0]  o_run_start,
    output logic                       o_block_busy
);

    localparam int CHUNK   = cba_pkg::CHUNK;
    localparam int CHUNK_W = cba_pkg::CHUNK_W;
    localparam int LEN_W   = cba_pkg::LEN_W;
    localparam int IDX_W   = $clog2(NUM_BLOCKS);
    localparam int NCHUNK  = (NUM_BLOCKS + CHUNK - 1) / CHUNK;
    localparam int CW      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int NPAD    = 2 ** CW;
    localparam int SW      = (IDX_W > cba_pkg::BLK_W) ? IDX_W : cba_pkg::BLK_W;
    localparam int EW      = (((CW + CHUNK_W) > LEN_W) ? (CW + CHUNK_W) : LEN_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MARK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [NUM_BLOCKS-1:0]       r_map, n_map;
    logic                        r_ovalid, n_ovalid;
    logic [cba_pkg::STAT_W-1:0]  r_status, n_status;
    logic [cba_pkg::BLK_W-1:0]   r_ostart, n_ostart;
    logic                        r_busy, n_busy;
    logic [LEN_W-1:0]            r_len, n_len;
    logic [CW-1:0]               r_pos, n_pos;
    logic [LEN_W-1:0]            r_run, n_run;
    logic [SW-1:0]               r_rstart, n_rstart;

    logic                        w_slot;
    logic [NPAD*CHUNK-1:0]       w_pad;
    logic [CHUNK-1:0]            w_chunk;
    logic [LEN_W-1:0]            w_run;
    logic                        w_hit;
    logic [CHUNK_W-1:0]          w_hit_k;
    logic [EW-1:0]               w_start;
    logic [EW-1:0]               w_lo;
    logic [EW-1:0]               w_hi;
    logic [NUM_BLOCKS-1:0]       w_mask;
    logic [SW-1:0]               w_blk_w;
    logic [IDX_W-1:0]            w_idx;

    assign o_valid      = r_ovalid;
    assign o_status     = r_status;
    assign o_run_start  = r_ostart;
    assign o_block_busy = r_busy;

    // output register can take a result this cycle
    assign w_slot = !r_ovalid || i_ready;

    assign w_blk_w = SW'(i_q_cmd.blk);
    assign w_idx   = w_blk_w[IDX_W-1:0];

    // blocks past the end read as used so no run crosses them
    always_comb begin
        w_pad = '1;
        w_pad[NUM_BLOCKS-1:0] = r_map;
    end

    assign w_chunk = w_pad[{r_pos, CHUNK_W'(0)} +: CHUNK];

    always_comb begin
        w_run   = r_run;
        w_hit   = 1'b0;
        w_hit_k = '0;
        for (int k = 0; k < CHUNK; k++) begin
            if (!w_hit) begin
                if (w_chunk[k]) begin
                    w_run = '0;
                end else begin
                    w_run = w_run + LEN_W'(1);
                    if (w_run == r_len) begin
                        w_hit   = 1'b1;
                        w_hit_k = CHUNK_W'(k);
                    end
                end
            end
        end
    end

    assign w_start = EW'({r_pos, w_hit_k}) + EW'(1) - EW'(r_len);

    assign w_lo = EW'(r_rstart);
    assign w_hi = w_lo + EW'(r_len);

    always_comb begin
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            w_mask[i] = (EW'(i) >= w_lo) && (EW'(i) < w_hi);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_map    = r_map;
        n_ovalid = r_ovalid && !i_ready;
        n_status = r_status;
        n_ostart = r_ostart;
        n_busy   = r_busy;
        n_len    = r_len;
        n_pos    = r_pos;
        n_run    = r_run;
        n_rstart = r_rstart;
        o_q_pop  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.op == cba_pkg::OP_ALLOC) begin
                        o_q_pop = 1'b1;
                        n_len   = i_q_cmd.len;
                        n_pos   = '0;
                        n_run   = '0;
                        n_state = S_SCAN;
                    end else if (w_slot) begin
                        o_q_pop  = 1'b1;
                        n_ovalid = 1'b1;
                        n_status = cba_pkg::ST_OK;
                        n_ostart = '0;
                        n_busy   = 1'b0;
                        case (i_q_cmd.op)
                            cba_pkg::OP_BAD: n_status = cba_pkg::ST_BAD_COUNT;
                            cba_pkg::OP_SET: begin
                                if (i_q_cmd.blk_ok) begin
                                    n_map[w_idx] = 1'b1;
                                end
                            end
                            cba_pkg::OP_CLEAR: begin
                                if (i_q_cmd.blk_ok) begin
                                    n_map[w_idx] = 1'b0;
                                end
                            end
                            cba_pkg::OP_QUERY: n_busy = i_q_cmd.blk_ok && r_map[w_idx];
                            default: ;
                        endcase
                    end
                end
            end
            S_SCAN: begin
                n_run = w_run;
                n_pos = r_pos + CW'(1);
                if (w_hit) begin
                    n_rstart = w_start[SW-1:0];
                    n_state  = S_MARK;
                end else if (r_pos == CW'(NCHUNK - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                // OR is idempotent, so holding here under a stall is harmless
                n_map = r_map | w_mask;
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_status = cba_pkg::ST_OK;
                    n_ostart = r_rstart[cba_pkg::BLK_W-1:0];
                    n_busy   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_DONE: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_status = cba_pkg::ST_NO_SPACE;
                    n_ostart = '0;
                    n_busy   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_map    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_map    <= n_map;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_ostart <= n_ostart;
        r_busy   <= n_busy;
        r_len    <= n_len;
        r_pos    <= n_pos;
        r_run    <= n_run;
        r_rstart <= n_rstart;
    end

endmodule

// File: rtl/core/contiguous_block_allocator_core.sv
// Channel   Dir  Handshake                        Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: run_length, block_index
//                                                 tuser: req_type
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: status, run_start, block_busy
//
// The back end answers mark, free, query and bad-count requests from S_IDLE.
// An allocate makes the back end scan the map 8 blocks per cycle until the chunk
// that completes the run; it then marks the run (or flags no space) and posts
// the result.
// Reset clears the whole map at once; there is no clearing pass.
// The request queue keeps the input open while the back end scans or the
// output register waits on i_m_axis_tready, until the queue is full.
module contiguous_block_allocator_core #(
    parameter int NUM_BLOCKS = cba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [cba_pkg::DATA_W-1:0] i_s_axis_tdata,  // run_length[6:0], block_index[12:7]
    input  logic [cba_pkg::REQ_W-1:0]  i_s_axis_tuser,  // req_type[1:0]
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [cba_pkg::DATA_W-1:0] o_m_axis_tdata   // status[1:0], run_start[7:2],
                                                        // block_busy[8]
);

    logic                       w_q_full;
    logic                       w_q_push;
    cba_pkg::t_cmd              w_push_cmd;
    logic                       w_q_valid;
    cba_pkg::t_cmd              w_pop_cmd;
    logic                       w_q_pop;
    logic [cba_pkg::STAT_W-1:0] w_status;
    logic [cba_pkg::BLK_W-1:0]  w_run_start;
    logic                       w_block_busy;

    cba_front #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_front (
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_req_type   (i_s_axis_tuser),
        .i_run_length (i_s_axis_tdata[6:0]),
        .i_block_index(i_s_axis_tdata[12:7]),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_cmd      (w_push_cmd)
    );

    cba_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_cmd  (w_push_cmd),
        .o_full (w_q_full),
        .o_valid(w_q_valid),
        .o_cmd  (w_pop_cmd),
        .i_pop  (w_q_pop)
    );

    cba_back #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_pop_cmd),
        .o_q_pop     (w_q_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_status    (w_status),
        .o_run_start (w_run_start),
        .o_block_busy(w_block_busy)
    );

    assign o_m_axis_tdata = {7'd0, w_block_busy, w_run_start, w_status};

endmodule
